@@ sv/assert_macros.svh @@
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/ufr_pkg.sv @@
// Package with the types, codes and CRC function of the framed UART receiver.
package ufr_pkg;

    localparam int HEADER_BYTES  = 12;
    localparam int TRAILER_BYTES = 8;

    localparam logic [31:0] PREAMBLE   = 32'hAAEEAAEE;
    localparam logic [31:0] DELIMITER  = 32'hAEAEAEAE;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

    localparam logic [7:0] CHAR_D = 8'h64;
    localparam logic [7:0] CHAR_R = 8'h72;
    localparam logic [7:0] CHAR_C = 8'h63;
    localparam logic [7:0] CHAR_I = 8'h69;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_TRIGGER = 2'd2,
        OP_RESET   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_PAYLOAD_LENGTH  = 3'd0,
        REG_PIXEL_TYPE_SIZE = 3'd1,
        REG_MULTIPLEX_ROWS  = 3'd2,
        REG_COLUMN_COUNT    = 3'd3,
        REG_TIMEOUT_TICKS   = 3'd4
    } reg_idx_t;

    localparam logic [2:0] STATUS_IDLE_EVEN    = 3'd0;
    localparam logic [2:0] STATUS_IDLE_ODD     = 3'd1;
    localparam logic [2:0] STATUS_HEADER_DONE  = 3'd2;
    localparam logic [2:0] STATUS_PAYLOAD_DONE = 3'd3;
    localparam logic [2:0] STATUS_READY        = 3'd4;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [7:0]  pixel_type_size;
        logic [7:0]  multiplex_rows;
        logic [7:0]  column_count;
        logic [15:0] timeout_ticks;
    } ufr_cfg_t;

    typedef struct packed {
        logic [2:0]  link_status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_offset;
        logic        frame_release;
        logic        new_id_valid;
        logic [7:0]  new_id;
    } ufr_result_t;

    // Reflected CRC-32, one byte per call.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ sv/ufr_cfg.sv @@
// APB configuration registers of the framed UART receiver.
module ufr_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ufr_pkg::ufr_cfg_t cfg
);
    import ufr_pkg::*;

    ufr_cfg_t cfg_reg;
    ufr_cfg_t cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_PAYLOAD_LENGTH:  cfg_next.payload_length  = pwdata[15:0];
                REG_PIXEL_TYPE_SIZE: cfg_next.pixel_type_size = pwdata[7:0];
                REG_MULTIPLEX_ROWS:  cfg_next.multiplex_rows  = pwdata[7:0];
                REG_COLUMN_COUNT:    cfg_next.column_count    = pwdata[7:0];
                REG_TIMEOUT_TICKS:   cfg_next.timeout_ticks   = pwdata[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PAYLOAD_LENGTH:  prdata = {16'd0, cfg_reg.payload_length};
            REG_PIXEL_TYPE_SIZE: prdata = {24'd0, cfg_reg.pixel_type_size};
            REG_MULTIPLEX_ROWS:  prdata = {24'd0, cfg_reg.multiplex_rows};
            REG_COLUMN_COUNT:    prdata = {24'd0, cfg_reg.column_count};
            REG_TIMEOUT_TICKS:   prdata = {16'd0, cfg_reg.timeout_ticks};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.payload_length  <= 16'd0;
            cfg_reg.pixel_type_size <= 8'd2;
            cfg_reg.multiplex_rows  <= 8'd16;
            cfg_reg.column_count    <= 8'd64;
            cfg_reg.timeout_ticks   <= 16'd1000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/ufr_core.sv @@
// Frame parser: phase, counters, CRC and header/trailer store, updated once per beat.
module ufr_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [1:0]           operation,
    input  logic [7:0]           rx_byte,
    input  ufr_pkg::ufr_cfg_t    cfg,
    output ufr_pkg::ufr_result_t result
);
    import ufr_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER, PH_PAYLOAD, PH_TRAILER, PH_READY
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA, KIND_RAW, KIND_SETID
    } kind_t;

    phase_t      phase_reg, phase_next, enter_ph;
    kind_t       kind_reg, kind_next;
    logic        parity_reg, parity_next;
    logic [15:0] count_reg, count_next, count_inc;
    logic [15:0] ticks_reg, ticks_next, ticks_sat;
    logic [31:0] crc_reg, crc_next, crc_upd;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  store_reg [HEADER_BYTES];
    logic [7:0]  store_next [HEADER_BYTES];
    logic        store_wr;
    logic        do_idle, do_enter;
    logic [31:0] word0, word1, word2;
    logic        delim_ok, crc_ok;
    op_t         op;

    assign op        = op_t'(operation);
    assign count_inc = count_reg + 16'd1;
    assign crc_upd   = crc32_byte(crc_reg, rx_byte);
    assign ticks_sat = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;

    // Store as it looks with the current byte written, so the last byte joins the check.
    always_comb begin
        store_next = store_reg;
        store_wr   = (op == OP_BYTE) && (phase_reg == PH_HEADER || phase_reg == PH_TRAILER)
                     && (count_reg < 16'(HEADER_BYTES));
        if (store_wr) begin
            store_next[count_reg[3:0]] = rx_byte;
        end
    end

    assign word0    = {store_next[0], store_next[1], store_next[2], store_next[3]};
    assign word1    = {store_next[4], store_next[5], store_next[6], store_next[7]};
    assign word2    = {store_next[8], store_next[9], store_next[10], store_next[11]};
    assign delim_ok = (word1 == DELIMITER);
    assign crc_ok   = (word0 == ~crc_reg);

    always_comb begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        parity_next = parity_reg;
        count_next  = count_reg;
        ticks_next  = ticks_reg;
        crc_next    = crc_reg;
        id_next     = id_reg;
        do_idle     = 1'b0;
        do_enter    = 1'b0;
        enter_ph    = PH_HEADER;
        result      = '0;

        unique case (op)
            OP_BYTE: begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        crc_next   = crc_upd;
                        count_next = count_inc;
                        if (count_inc >= 16'(HEADER_BYTES)) begin
                            do_idle = 1'b1;
                            if (word0 == PREAMBLE) begin
                                if (store_next[5] == CHAR_D &&
                                    (store_next[4] == CHAR_D || store_next[4] == CHAR_R)) begin
                                    if ({store_next[6], store_next[7]} == cfg.payload_length &&
                                        store_next[8] == cfg.pixel_type_size &&
                                        store_next[9] == cfg.multiplex_rows &&
                                        store_next[10] == cfg.column_count &&
                                        store_next[11] == 8'd0) begin
                                        do_idle   = 1'b0;
                                        do_enter  = 1'b1;
                                        kind_next = (store_next[4] == CHAR_D) ? KIND_DATA
                                                                               : KIND_RAW;
                                        enter_ph  = (cfg.payload_length == 16'd0) ? PH_TRAILER
                                                                                  : PH_PAYLOAD;
                                    end
                                end else if (store_next[5] == CHAR_C &&
                                             store_next[4] == CHAR_I) begin
                                    if ({store_next[6], store_next[7]} == 16'd1 &&
                                        word2 == 32'd0) begin
                                        do_idle   = 1'b0;
                                        do_enter  = 1'b1;
                                        kind_next = KIND_SETID;
                                        enter_ph  = PH_PAYLOAD;
                                    end
                                end
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        if (kind_reg == KIND_SETID) begin
                            id_next  = rx_byte;
                            crc_next = crc_upd;
                            do_enter = 1'b1;
                            enter_ph = PH_TRAILER;
                        end else begin
                            result.payload_valid  = 1'b1;
                            result.payload_byte   = rx_byte;
                            result.payload_offset = count_reg;
                            if (kind_reg == KIND_DATA) begin
                                crc_next = crc_upd;
                            end
                            count_next = count_inc;
                            if (count_inc >= cfg.payload_length) begin
                                do_enter = 1'b1;
                                enter_ph = PH_TRAILER;
                            end
                        end
                    end
                    PH_TRAILER: begin
                        count_next = count_inc;
                        if (count_inc >= 16'(TRAILER_BYTES)) begin
                            priority if (delim_ok && kind_reg == KIND_RAW) begin
                                do_enter = 1'b1;
                                enter_ph = PH_READY;
                            end else if (delim_ok && crc_ok && kind_reg == KIND_DATA) begin
                                do_enter = 1'b1;
                                enter_ph = PH_READY;
                            end else if (delim_ok && crc_ok && kind_reg == KIND_SETID) begin
                                result.new_id_valid = 1'b1;
                                result.new_id       = id_reg;
                                parity_next         = ~parity_reg;
                                do_idle             = 1'b1;
                            end else begin
                                do_idle = 1'b1;
                            end
                        end
                    end
                    PH_READY: begin
                        // Bytes are dropped while a frame waits for its trigger.
                    end
                    default: begin
                    end
                endcase
            end
            OP_TICK: begin
                ticks_next = ticks_sat;
                if (ticks_sat >= cfg.timeout_ticks) begin
                    do_idle = 1'b1;
                end
            end
            OP_TRIGGER: begin
                if (phase_reg == PH_READY) begin
                    result.frame_release = 1'b1;
                    parity_next          = ~parity_reg;
                    do_idle              = 1'b1;
                end
            end
            OP_RESET: begin
                do_idle = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_idle) begin
            phase_next = PH_HEADER;
            count_next = 16'd0;
            ticks_next = 16'd0;
            crc_next   = CRC_INIT;
        end else if (do_enter) begin
            phase_next = enter_ph;
            count_next = 16'd0;
            ticks_next = 16'd0;
        end

        unique case (phase_next)
            PH_PAYLOAD: result.link_status = STATUS_HEADER_DONE;
            PH_TRAILER: result.link_status = STATUS_PAYLOAD_DONE;
            PH_READY:   result.link_status = STATUS_READY;
            default:    result.link_status = parity_next ? STATUS_IDLE_ODD : STATUS_IDLE_EVEN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            kind_reg   <= KIND_DATA;
            parity_reg <= 1'b0;
            count_reg  <= 16'd0;
            ticks_reg  <= 16'd0;
            crc_reg    <= CRC_INIT;
            id_reg     <= 8'd0;
        end else if (step) begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            parity_reg <= parity_next;
            count_reg  <= count_next;
            ticks_reg  <= ticks_next;
            crc_reg    <= crc_next;
            id_reg     <= id_next;
        end
    end

    // The store has no reset; every entry read by a check was written in the same phase.
    always_ff @(posedge aclk) begin
        if (step) begin
            store_reg <= store_next;
        end
    end

endmodule

@@ sv/uart_frame_receiver_top.sv @@
// A beat is held in the input register, then its result in the output register that drives m_*.
// One beat per cycle while m_ready drains the result register; the parser state updates once per beat.
// While a result waits, the input register can still take one beat; the input stalls once
// a result is waiting and a beat is already held.
// Reset (aresetn low, synchronous): both channels empty, parser idle with even parity,
// CRC preset, configuration registers back to their defaults.
module uart_frame_receiver_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_link_status,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_payload_offset,
    output logic        m_frame_release,
    output logic        m_new_id_valid,
    output logic [7:0]  m_new_id,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ufr_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_op_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    ufr_result_t out_reg;
    ufr_result_t result;
    ufr_cfg_t    cfg;
    logic        advance;

    ufr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ufr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .operation (in_op_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // A held beat moves on whenever the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_operation;
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_link_status    = out_reg.link_status;
    assign m_payload_valid  = out_reg.payload_valid;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_payload_offset = out_reg.payload_offset;
    assign m_frame_release  = out_reg.frame_release;
    assign m_new_id_valid   = out_reg.new_id_valid;
    assign m_new_id         = out_reg.new_id;

endmodule

@@ sv/ufr_checker.sv @@
// Port-level checker for the framed UART receiver, bound to the top level.
`include "assert_macros.svh"

module ufr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_link_status,
    input logic        m_payload_valid,
    input logic [7:0]  m_payload_byte,
    input logic [15:0] m_payload_offset,
    input logic        m_frame_release,
    input logic        m_new_id_valid,
    input logic [7:0]  m_new_id
);
    import ufr_pkg::*;

    // A beat carries at most one of payload byte, release and new id.
    `ASSERT_IMP(a_single_event, aclk, aresetn, m_valid, $onehot0({m_payload_valid, m_frame_release, m_new_id_valid}))

    // A payload byte leaves the parser in the payload or trailer phase.
    `ASSERT_IMP(a_payload_phase, aclk, aresetn, m_valid && m_payload_valid, m_link_status == STATUS_HEADER_DONE || m_link_status == STATUS_PAYLOAD_DONE)

    // Release and a delivered id both end the frame, so the status is idle.
    `ASSERT_IMP(a_done_idle, aclk, aresetn, m_valid && (m_frame_release || m_new_id_valid), m_link_status == STATUS_IDLE_EVEN || m_link_status == STATUS_IDLE_ODD)

    // Without a payload byte the byte and offset fields are zero.
    `ASSERT_IMP(a_payload_zero, aclk, aresetn, m_valid && !m_payload_valid, m_payload_byte == 8'd0 && m_payload_offset == 16'd0)

    // A stalled result beat holds.
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_link_status) && $stable(m_payload_offset) && $stable(m_new_id))

endmodule

bind uart_frame_receiver_top ufr_checker u_ufr_checker (.*);
